// ----- rtl/core/bfie_pkg.sv -----
`timescale 1ns / 1ps

package bfie_pkg;

    // Field widths fixed by the interface
    localparam int PL_W   = 13;
    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;

    // Request operations
    localparam logic OP_LOAD = 1'b0;

    // Program characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    // Microprogram step addresses
    localparam logic [3:0] U_IDLE = 4'd0;
    localparam logic [3:0] U_SORT = 4'd1;
    localparam logic [3:0] U_CHKH = 4'd2;
    localparam logic [3:0] U_EXEC = 4'd3;
    localparam logic [3:0] U_SDIR = 4'd4;
    localparam logic [3:0] U_FREQ = 4'd5;
    localparam logic [3:0] U_FCHK = 4'd6;
    localparam logic [3:0] U_BREQ = 4'd7;
    localparam logic [3:0] U_BCHK = 4'd8;
    localparam logic [3:0] U_LOAD = 4'd9;
    localparam logic [3:0] U_RESP = 4'd10;

    // Datapath actions
    localparam logic [3:0] A_NONE  = 4'd0;
    localparam logic [3:0] A_LATCH = 4'd1;
    localparam logic [3:0] A_EXEC  = 4'd2;
    localparam logic [3:0] A_FTEST = 4'd3;
    localparam logic [3:0] A_FCHK  = 4'd4;
    localparam logic [3:0] A_BTEST = 4'd5;
    localparam logic [3:0] A_BCHK  = 4'd6;
    localparam logic [3:0] A_LOAD  = 4'd7;
    localparam logic [3:0] A_RESP  = 4'd8;

    // Branch conditions
    localparam logic [3:0] C_TRUE      = 4'd0;
    localparam logic [3:0] C_FIRE      = 4'd1;
    localparam logic [3:0] C_OP_LOAD   = 4'd2;
    localparam logic [3:0] C_HALTED    = 4'd3;
    localparam logic [3:0] C_SCAN_GO   = 4'd4;
    localparam logic [3:0] C_SCAN_BACK = 4'd5;
    localparam logic [3:0] C_SCAN_END  = 4'd6;
    localparam logic [3:0] C_SCAN_ZERO = 4'd7;
    localparam logic [3:0] C_FMATCH    = 4'd8;
    localparam logic [3:0] C_BMATCH    = 4'd9;
    localparam logic [3:0] C_OUT_FREE  = 4'd10;

    // Code read address select
    localparam logic [1:0] RA_PC       = 2'd0;
    localparam logic [1:0] RA_SCAN     = 2'd1;
    localparam logic [1:0] RA_SCAN_DEC = 2'd2;

    typedef struct packed {
        logic       accept;
        logic [1:0] ra;
        logic [3:0] act;
        logic [3:0] cond;
        logic [3:0] t_true;
        logic [3:0] t_false;
    } ucw_t;

    function automatic ucw_t ucode_rom(input logic [3:0] upc);
        ucw_t w;
        unique case (upc)
            U_IDLE: w = '{1'b1, RA_PC,       A_LATCH, C_FIRE,      U_SORT, U_IDLE};
            U_SORT: w = '{1'b0, RA_PC,       A_NONE,  C_OP_LOAD,   U_LOAD, U_CHKH};
            U_CHKH: w = '{1'b0, RA_PC,       A_NONE,  C_HALTED,    U_RESP, U_EXEC};
            U_EXEC: w = '{1'b0, RA_PC,       A_EXEC,  C_SCAN_GO,   U_SDIR, U_RESP};
            U_SDIR: w = '{1'b0, RA_PC,       A_NONE,  C_SCAN_BACK, U_BREQ, U_FREQ};
            U_FREQ: w = '{1'b0, RA_SCAN,     A_FTEST, C_SCAN_END,  U_RESP, U_FCHK};
            U_FCHK: w = '{1'b0, RA_SCAN,     A_FCHK,  C_FMATCH,    U_RESP, U_FREQ};
            U_BREQ: w = '{1'b0, RA_SCAN_DEC, A_BTEST, C_SCAN_ZERO, U_RESP, U_BCHK};
            U_BCHK: w = '{1'b0, RA_SCAN,     A_BCHK,  C_BMATCH,    U_RESP, U_BREQ};
            U_LOAD: w = '{1'b0, RA_PC,       A_LOAD,  C_TRUE,      U_RESP, U_RESP};
            U_RESP: w = '{1'b0, RA_PC,       A_RESP,  C_OUT_FREE,  U_IDLE, U_RESP};
            default: w = '{1'b0, RA_PC,      A_NONE,  C_TRUE,      U_IDLE, U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/brainfuck_instruction_executor.sv -----
`timescale 1ns / 1ps

// Brainfuck instruction executor.
// Request channel (req_valid/req_ready): a load request writes code_byte at
// code_address into the code store; an execute request runs the instruction
// at the program counter, with in_byte offered to a comma.
// Response channel (rsp_valid/rsp_ready): exactly one response per request,
// carrying out_valid/out_byte (dot), input_taken (comma), halted,
// bracket_error and program_counter after the request.
// cfg_wr_en/cfg_wr_data write program_length; write only while idle.
// Control is a microprogram of 11 steps held in a ROM; one request at a time.
// Steps per request: load runs sort, load, respond; execute runs sort, halt
// check, execute, respond, skipping execute while halted. A bracket jump adds
// a direction step, then one code store read and one compare step per code
// byte scanned; a scan that finds no partner ends with a final end check.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only holds the sequencer at its final
// step until the previous response is taken.
// Reset: the tape is zeroed by a clearing pass over every tape address,
// during which req_ready stays low; pointers, counters and the error flag are
// cleared at once. Code store contents are undefined until loaded.

module brainfuck_instruction_executor
    import bfie_pkg::*;
#(
    parameter int CODE_DEPTH = 4096,
    parameter int TAPE_DEPTH = 32768
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [PL_W-1:0]   cfg_wr_data,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              operation,
    input  logic [ADDR_W-1:0] code_address,
    input  logic [BYTE_W-1:0] code_byte,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              input_taken,
    output logic              halted,
    output logic              bracket_error,
    output logic [PL_W-1:0]   program_counter
);

    localparam int CAW = $clog2(CODE_DEPTH);
    localparam int PCW = CAW + 1;
    localparam int TPW = $clog2(TAPE_DEPTH);
    localparam int LW  = (PCW > PL_W) ? PCW : PL_W;
    localparam logic [LW-1:0]  CODE_LIMIT = LW'(CODE_DEPTH);
    localparam logic [TPW-1:0] TAPE_LAST  = TPW'(TAPE_DEPTH - 1);

    // Memories
    logic [BYTE_W-1:0] code_mem [CODE_DEPTH];
    logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];
    logic [BYTE_W-1:0] code_rd_reg;
    logic [BYTE_W-1:0] tape_rd_reg;

    // Control state
    logic [3:0]      upc_reg, upc_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic [TPW-1:0]  ptr_reg, ptr_next;
    logic            error_reg, error_next;
    logic [PL_W-1:0] prog_len_reg;
    logic            clearing_reg;
    logic [TPW-1:0]  clr_cnt_reg;
    logic            rsp_valid_reg, rsp_valid_next;

    // Datapath payload
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] cbyte_reg, cbyte_next;
    logic [BYTE_W-1:0] inb_reg, inb_next;
    logic [PCW-1:0]    scan_reg, scan_next;
    logic [PCW-1:0]    depth_reg, depth_next;
    logic              scan_back_reg, scan_back_next;
    logic              ev_out_reg, ev_out_next;
    logic [BYTE_W-1:0] ev_byte_reg, ev_byte_next;
    logic              ev_taken_reg, ev_taken_next;
    logic              o_valid_reg, o_valid_next;
    logic [BYTE_W-1:0] o_byte_reg, o_byte_next;
    logic              o_taken_reg, o_taken_next;
    logic              o_halted_reg, o_halted_next;
    logic              o_err_reg, o_err_next;
    logic [PL_W-1:0]   o_pc_reg, o_pc_next;

    // Combinational control
    ucw_t              ucw;
    logic              fire;
    logic              cond;
    logic [LW-1:0]     eff_len;
    logic              halted_now;
    logic              scan_needed;
    logic              out_free;
    logic [PCW-1:0]    scan_dec;
    logic [CAW-1:0]    code_ra;
    logic              code_we;
    logic              tape_we;
    logic [TPW-1:0]    tape_wa;
    logic [BYTE_W-1:0] tape_wd;

    assign ucw       = ucode_rom(upc_reg);
    assign req_ready = ucw.accept && !clearing_reg;
    assign fire      = req_valid && req_ready;
    assign eff_len   = (LW'(prog_len_reg) > CODE_LIMIT) ? CODE_LIMIT : LW'(prog_len_reg);
    assign halted_now  = error_reg || (LW'(pc_reg) >= eff_len);
    assign scan_needed = ((code_rd_reg == CH_OPEN) && (tape_rd_reg == '0))
                      || ((code_rd_reg == CH_CLOSE) && (tape_rd_reg != '0));
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign scan_dec  = scan_reg - PCW'(1);

    // Branch condition select
    always_comb
    begin
        unique case (ucw.cond)
            C_TRUE:      cond = 1'b1;
            C_FIRE:      cond = fire;
            C_OP_LOAD:   cond = (op_reg == OP_LOAD);
            C_HALTED:    cond = halted_now;
            C_SCAN_GO:   cond = scan_needed;
            C_SCAN_BACK: cond = scan_back_reg;
            C_SCAN_END:  cond = (LW'(scan_reg) >= eff_len);
            C_SCAN_ZERO: cond = (scan_reg == '0);
            C_FMATCH:    cond = (code_rd_reg == CH_CLOSE) && (depth_reg == PCW'(1));
            C_BMATCH:    cond = (code_rd_reg == CH_OPEN) && (depth_reg == PCW'(1));
            C_OUT_FREE:  cond = out_free;
            default:     cond = 1'b0;
        endcase
        upc_next = cond ? ucw.t_true : ucw.t_false;
    end

    // Code store read address
    always_comb
    begin
        unique case (ucw.ra)
            RA_SCAN:     code_ra = scan_reg[CAW-1:0];
            RA_SCAN_DEC: code_ra = scan_dec[CAW-1:0];
            default:     code_ra = pc_reg[CAW-1:0];
        endcase
    end

    // Datapath actions
    always_comb
    begin
        pc_next        = pc_reg;
        ptr_next       = ptr_reg;
        error_next     = error_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        op_next        = op_reg;
        addr_next      = addr_reg;
        cbyte_next     = cbyte_reg;
        inb_next       = inb_reg;
        scan_next      = scan_reg;
        depth_next     = depth_reg;
        scan_back_next = scan_back_reg;
        ev_out_next    = ev_out_reg;
        ev_byte_next   = ev_byte_reg;
        ev_taken_next  = ev_taken_reg;
        o_valid_next   = o_valid_reg;
        o_byte_next    = o_byte_reg;
        o_taken_next   = o_taken_reg;
        o_halted_next  = o_halted_reg;
        o_err_next     = o_err_reg;
        o_pc_next      = o_pc_reg;
        code_we        = 1'b0;
        tape_we        = 1'b0;
        tape_wa        = ptr_reg;
        tape_wd        = tape_rd_reg;

        unique case (ucw.act)
            A_LATCH:
            begin
                if (fire)
                begin
                    op_next       = operation;
                    addr_next     = code_address;
                    cbyte_next    = code_byte;
                    inb_next      = in_byte;
                    ev_out_next   = 1'b0;
                    ev_byte_next  = '0;
                    ev_taken_next = 1'b0;
                end
            end
            A_EXEC:
            begin
                pc_next        = pc_reg + PCW'(1);
                scan_back_next = (code_rd_reg == CH_CLOSE);
                depth_next     = PCW'(1);
                unique case (code_rd_reg)
                    CH_PLUS:
                    begin
                        tape_we = 1'b1;
                        tape_wd = tape_rd_reg + 8'd1;
                    end
                    CH_MINUS:
                    begin
                        tape_we = 1'b1;
                        tape_wd = tape_rd_reg - 8'd1;
                    end
                    CH_GT:    ptr_next = (ptr_reg == TAPE_LAST) ? '0 : ptr_reg + TPW'(1);
                    CH_LT:    ptr_next = (ptr_reg == '0) ? TAPE_LAST : ptr_reg - TPW'(1);
                    CH_DOT:
                    begin
                        ev_out_next  = 1'b1;
                        ev_byte_next = tape_rd_reg;
                    end
                    CH_COMMA:
                    begin
                        tape_we       = 1'b1;
                        tape_wd       = inb_reg;
                        ev_taken_next = 1'b1;
                    end
                    CH_OPEN, CH_CLOSE:
                    begin
                        if (scan_needed)
                        begin
                            pc_next   = pc_reg;
                            scan_next = (code_rd_reg == CH_OPEN) ? pc_reg + PCW'(1) : pc_reg;
                        end
                    end
                    default: ;
                endcase
            end
            A_FTEST:
            begin
                if (LW'(scan_reg) >= eff_len)
                    error_next = 1'b1;
            end
            A_FCHK:
            begin
                if ((code_rd_reg == CH_CLOSE) && (depth_reg == PCW'(1)))
                    pc_next = scan_reg + PCW'(1);
                else
                begin
                    scan_next = scan_reg + PCW'(1);
                    if (code_rd_reg == CH_CLOSE)
                        depth_next = depth_reg - PCW'(1);
                    else if (code_rd_reg == CH_OPEN)
                        depth_next = depth_reg + PCW'(1);
                end
            end
            A_BTEST:
            begin
                if (scan_reg == '0)
                    error_next = 1'b1;
                else
                    scan_next = scan_dec;
            end
            A_BCHK:
            begin
                if ((code_rd_reg == CH_OPEN) && (depth_reg == PCW'(1)))
                    pc_next = scan_reg + PCW'(1);
                else if (code_rd_reg == CH_OPEN)
                    depth_next = depth_reg - PCW'(1);
                else if (code_rd_reg == CH_CLOSE)
                    depth_next = depth_reg + PCW'(1);
            end
            A_LOAD:   code_we = 1'b1;
            A_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    o_valid_next   = ev_out_reg;
                    o_byte_next    = ev_byte_reg;
                    o_taken_next   = ev_taken_reg;
                    o_halted_next  = halted_now;
                    o_err_next     = error_reg;
                    o_pc_next      = PL_W'(pc_reg);
                end
            end
            default: ;
        endcase

        // Clearing pass owns the tape write port after reset
        if (clearing_reg)
        begin
            tape_we = 1'b1;
            tape_wa = clr_cnt_reg;
            tape_wd = '0;
        end
    end

    // Code store
    always_ff @(posedge clk)
    begin
        if (code_we)
            code_mem[CAW'(addr_reg)] <= cbyte_reg;
        code_rd_reg <= code_mem[code_ra];
    end

    // Tape
    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[tape_wa] <= tape_wd;
        tape_rd_reg <= tape_mem[ptr_reg];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= U_IDLE;
            pc_reg        <= '0;
            ptr_reg       <= '0;
            error_reg     <= 1'b0;
            prog_len_reg  <= '0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            pc_reg        <= pc_next;
            ptr_reg       <= ptr_next;
            error_reg     <= error_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                prog_len_reg <= cfg_wr_data;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + TPW'(1);
                if (clr_cnt_reg == TAPE_LAST)
                    clearing_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        cbyte_reg     <= cbyte_next;
        inb_reg       <= inb_next;
        scan_reg      <= scan_next;
        depth_reg     <= depth_next;
        scan_back_reg <= scan_back_next;
        ev_out_reg    <= ev_out_next;
        ev_byte_reg   <= ev_byte_next;
        ev_taken_reg  <= ev_taken_next;
        o_valid_reg   <= o_valid_next;
        o_byte_reg    <= o_byte_next;
        o_taken_reg   <= o_taken_next;
        o_halted_reg  <= o_halted_next;
        o_err_reg     <= o_err_next;
        o_pc_reg      <= o_pc_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign out_valid       = o_valid_reg;
    assign out_byte        = o_byte_reg;
    assign input_taken     = o_taken_reg;
    assign halted          = o_halted_reg;
    assign bracket_error   = o_err_reg;
    assign program_counter = o_pc_reg;

    // Bracket error is sticky until reset
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("bracket error flag dropped");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && bracket_error) |-> halted)
        else $error("bracket error reported without halt");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_valid) |-> !input_taken)
        else $error("dot and comma reported in one response");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PCW'(CODE_DEPTH))
        else $error("program counter past code store");

    a_depth_live: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == U_FCHK || upc_reg == U_BCHK) |-> (depth_reg != '0))
        else $error("nesting depth reached zero during scan");

endmodule
